/* src/bb3_pkg.sv */
package bb3_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;
  localparam int MIN_DIM      = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // nine 8-bit terms plus rounding offset
  localparam int SUM_W = 12;

  // reciprocals for the rounded divide, exact for sums below 2^SUM_W
  localparam int RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP6 = 14'd10923;
  localparam logic [13:0] RECIP9 = 14'd7282;
  localparam int PROD_W = SUM_W + 14;

  typedef struct packed {
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blur_red;
    logic [7:0] blur_green;
    logic [7:0] blur_blue;
    logic       frame_end;
  } pix_out_t;

  // edge masks and flags carried with an item down the pipe
  typedef struct packed {
    logic produce;
    logic last;
    logic top;
    logic bot;
    logic left;
    logic right;
  } win_ctl_t;

endpackage

/* src/box_blur_3x3_rgb.sv */
// 3x3 box blur on an RGB raster stream. Takes one item per clock while the
// output is not stalled and gives at most one result per item; a pixel's
// blurred value leaves with the item frame_width+1 positions after it, so
// after the last pixel of a frame the source sends frame_width+1 drain items
// (a pixel item sent then counts as a drain). Edges average over 4 (corner),
// 6 (edge) or 9 pixels, rounded half up, and the frame's last result has
// frame_end set. Internally an item passes a row-store read stage, a window
// stage, a sum stage and a divide stage into the output register; the rate
// is one item per cycle unless the output stalls, set by the row-store
// RAMs, each of which is read at accept and written back one stage later at
// the previous item's column in the same cycle (one read port and one write
// port). Writing frame_width or frame_height (clamped to 2..MAX) restarts the
// frame; write only when idle. The row stores are not cleared after reset:
// entries not yet written only reach window taps that the frame edges mask.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bb3_pkg::pix_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bb3_pkg::pix_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bb3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          adv;
  logic          take;
  logic          draining;
  win_ctl_t      ctl_in;
  logic [RW-1:0] cr;
  logic [CW-1:0] cc;
  logic [23:0]   pix_in;
  logic          cfg_wr;
  logic          cfg_restart;

  logic          s1_valid_r;
  win_ctl_t      s1_ctl_r;
  logic [CW-1:0] s1_col_r;
  logic [23:0]   s1_pix_r;
  logic [23:0]   up_rd_r, lo_rd_r;

  logic [23:0]   upper_mem [MAX_WIDTH];
  logic [23:0]   lower_mem [MAX_WIDTH];

  logic          s2_valid_r;
  win_ctl_t      s2_ctl_r;
  logic [23:0]   win_r [9];

  logic             s3_valid_r;
  win_ctl_t         s3_ctl_r;
  logic [SUM_W-1:0] s3_sum_r [3];
  logic [SUM_W-1:0] sum_nxt [3];

  logic             out_valid_r;
  pix_out_t         out_data_r;
  logic [7:0]       quot [3];

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // only writes to a defined register restart the frame
  assign cfg_restart = cfg_wr &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- configuration ----------------
  always_comb begin
    int vw, vh;
    vw = int'(cfg_data[FW_BITS-1:0]);
    vh = int'(cfg_data[FH_BITS-1:0]);
    if (vw < MIN_DIM) vw = MIN_DIM;
    if (vw > MAX_WIDTH) vw = MAX_WIDTH;
    if (vh < MIN_DIM) vh = MIN_DIM;
    if (vh > MAX_HEIGHT) vh = MAX_HEIGHT;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr && cfg_index == REG_FRAME_WIDTH) width_nxt = WW'(vw);
    if (cfg_wr && cfg_index == REG_FRAME_HEIGHT) height_nxt = HW'(vh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= HW'(RST_H);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // ---------------- position tracking at accept ----------------
  always_comb begin
    draining = 32'(row_r) >= 32'(height_r);
    take     = in_valid && in_ready && !(in_data.opcode == OP_DRAIN && !draining);
    pix_in   = draining ? 24'd0 : {in_data.red, in_data.green, in_data.blue};

    if (col_r != '0) begin
      cr = RW'(row_r - 1'b1);
      cc = CW'(col_r - 1'b1);
    end else begin
      cr = RW'(row_r - 2'd2);
      cc = CW'(32'(width_r) - 1);
    end

    ctl_in.produce = (32'(row_r) >= 2) || (row_r == RW'(1) && col_r != '0);
    ctl_in.top     = cr == '0;
    ctl_in.bot     = 32'(cr) >= 32'(height_r) - 1;
    ctl_in.left    = cc == '0;
    ctl_in.right   = 32'(cc) >= 32'(width_r) - 1;
    ctl_in.last    = ctl_in.produce && 32'(cr) == 32'(height_r) - 1 &&
                     32'(cc) == 32'(width_r) - 1;

    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (ctl_in.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (32'(col_r) + 1 >= 32'(width_r)) begin
        col_nxt = '0;
        row_nxt = RW'(row_r + 1'b1);
      end else begin
        col_nxt = CW'(col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: row store read / write back ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      s1_ctl_r <= ctl_in;
      s1_col_r <= col_r;
      s1_pix_r <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) upper_mem[s1_col_r] <= lo_rd_r;
    if (adv && take) up_rd_r <= upper_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) lower_mem[s1_col_r] <= s1_pix_r;
    if (adv && take) lo_rd_r <= lower_mem[col_r];
  end

  // ---------------- stage 2: window shift ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_ctl_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_ctl_r <= s1_ctl_r;
      for (int r = 0; r < 3; r++) begin
        win_r[r*3+0] <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= up_rd_r;
      win_r[5] <= lo_rd_r;
      win_r[8] <= s1_pix_r;
    end
  end

  // ---------------- stage 3: masked sums ----------------
  always_comb begin
    logic use_tap;
    for (int k = 0; k < 3; k++) sum_nxt[k] = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        use_tap = !((r == 0 && s2_ctl_r.top) || (r == 2 && s2_ctl_r.bot) ||
                    (c == 0 && s2_ctl_r.left) || (c == 2 && s2_ctl_r.right));
        if (use_tap) begin
          sum_nxt[0] = sum_nxt[0] + SUM_W'(win_r[r*3+c][23:16]);
          sum_nxt[1] = sum_nxt[1] + SUM_W'(win_r[r*3+c][15:8]);
          sum_nxt[2] = sum_nxt[2] + SUM_W'(win_r[r*3+c][7:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      s3_ctl_r <= s2_ctl_r;
      for (int k = 0; k < 3; k++) s3_sum_r[k] <= sum_nxt[k];
    end
  end

  // ---------------- stage 4: rounded divide by 4, 6 or 9 ----------------
  always_comb begin
    logic             row_short, col_short;
    logic [SUM_W-1:0] x;
    logic [PROD_W-1:0] prod;
    row_short = s3_ctl_r.top || s3_ctl_r.bot;
    col_short = s3_ctl_r.left || s3_ctl_r.right;
    for (int k = 0; k < 3; k++) begin
      if (row_short && col_short) begin
        x       = s3_sum_r[k] + SUM_W'(2);
        prod    = '0;
        quot[k] = x[9:2];
      end else if (row_short || col_short) begin
        x       = s3_sum_r[k] + SUM_W'(3);
        prod    = PROD_W'(x) * PROD_W'(RECIP6);
        quot[k] = prod[RECIP_SHIFT+7:RECIP_SHIFT];
      end else begin
        x       = s3_sum_r[k] + SUM_W'(4);
        prod    = PROD_W'(x) * PROD_W'(RECIP9);
        quot[k] = prod[RECIP_SHIFT+7:RECIP_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      out_data_r.blur_red   <= quot[0];
      out_data_r.blur_green <= quot[1];
      out_data_r.blur_blue  <= quot[2];
      out_data_r.frame_end  <= s3_ctl_r.last;
    end
  end

  // ---------------- assertions ----------------
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(width_r))
    else $error("column counter outside frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) <= 32'(height_r) + 1)
    else $error("row counter past drain end");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ctl_in.last && !cfg_wr) |=> (col_r == '0 && row_r == '0))
    else $error("frame did not restart after its last item");

  a_mask_sane: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(s2_ctl_r.top && s2_ctl_r.bot) && !(s2_ctl_r.left && s2_ctl_r.right))
    else $error("window masked on both opposite sides");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !adv) |=> s3_valid_r)
    else $error("sum stage lost an item under stall");

endmodule

/* tb/sv/tb_box_blur_3x3_rgb.sv */
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb;
  import bb3_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int unsigned WHOLE_FRAME = 32'hFFFF_FFFF;
  localparam int unsigned TALL_CUT = 200;
  localparam int unsigned RANDOM_ITEMS = 420;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_BURSTY} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pix_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pix_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_3x3_rgb #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // blur predictor state
  bit [23:0]   line_upper [MAX_W];
  bit [23:0]   line_lower [MAX_W];
  bit [23:0]   win [9];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned seen_count = 0;
  int unsigned fw = RESET_WIDTH;
  int unsigned fh = RESET_HEIGHT;

  pix_in_t     pixel_items_q [$];
  pix_out_t    expected_blur_q [$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned random_count = 0;
  int unsigned mismatch_count = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_tick = 0;
  int unsigned rx_hold = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  pix_out_t    exp_px;

  function automatic void restart_frame();
    for (int k = 0; k < 9; k++) win[k] = '0;
    col_pos = 0;
    row_pos = 0;
    seen_count = 0;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) begin
      fw = clamp_dim(val[FW_BITS-1:0], MAX_W);
      restart_frame();
    end else if (idx == REG_FRAME_HEIGHT) begin
      fh = clamp_dim(val[FH_BITS-1:0], MAX_H);
      restart_frame();
    end
  endfunction

  // one accepted item: unless it is an early drain, slide the window and emit any blurred pixel it releases
  function automatic void predict_blur(pix_in_t it);
    int unsigned col, cr, cc, nr, nc, d;
    int unsigned sum [3];
    bit [23:0]   px, v;
    bit [2:0]    keep_r, keep_c;
    bit          drain_phase;
    pix_out_t    res;
    drain_phase = seen_count >= fw * fh;
    if (it.opcode == OP_DRAIN && !drain_phase) return;
    px = drain_phase ? 24'h0 : {it.red, it.green, it.blue};
    col = col_pos;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = line_upper[col];
    win[5] = line_lower[col];
    win[8] = px;
    line_upper[col] = line_lower[col];
    line_lower[col] = px;
    res = '0;
    if (seen_count >= fw + 1) begin
      if (col >= 1) begin
        cr = row_pos - 1;
        cc = col - 1;
      end else begin
        cr = row_pos - 2;
        cc = fw - 1;
      end
      keep_r = {cr < fh - 1, 1'b1, cr != 0};
      keep_c = {cc < fw - 1, 1'b1, cc != 0};
      nr = keep_r[0] + keep_r[1] + keep_r[2];
      nc = keep_c[0] + keep_c[1] + keep_c[2];
      sum = '{0, 0, 0};
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (keep_r[r] && keep_c[c]) begin
            v = win[r*3+c];
            sum[0] += v[23:16];
            sum[1] += v[15:8];
            sum[2] += v[7:0];
          end
        end
      end
      d = nr * nc;
      res.blur_red   = 8'((sum[0] + d / 2) / d);
      res.blur_green = 8'((sum[1] + d / 2) / d);
      res.blur_blue  = 8'((sum[2] + d / 2) / d);
      res.frame_end  = (cr == fh - 1) && (cc == fw - 1);
      expected_blur_q.push_back(res);
    end
    seen_count++;
    col_pos = col + 1;
    if (col_pos >= fw) begin
      col_pos = 0;
      row_pos++;
    end
    if (res.frame_end) restart_frame();
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_items_q.push_back('{opcode: op, red: r, green: g, blue: b});
    queued_count++;
  endfunction

  // sender: bursts of random length, random gaps, some bursts back to back
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_blur(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_items_q.size() != 0) begin
          in_data  <= pixel_items_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_blur_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing expected: %p", $realtime, out_data);
        end else begin
          exp_px = expected_blur_q.pop_front();
          if (out_data.blur_red !== exp_px.blur_red ||
              out_data.blur_green !== exp_px.blur_green ||
              out_data.blur_blue !== exp_px.blur_blue ||
              out_data.frame_end !== exp_px.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp r=%0d g=%0d b=%0d end=%0b got r=%0d g=%0d b=%0d end=%0b",
                       $realtime, exp_px.blur_red, exp_px.blur_green, exp_px.blur_blue,
                       exp_px.frame_end, out_data.blur_red, out_data.blur_green,
                       out_data.blur_blue, out_data.frame_end);
          end
        end
      end
      rx_tick++;
      if (rx_tick % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ready <= ((rx_tick % 7) < 4);
        default: begin
          if (rx_hold != 0) begin
            rx_hold--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  task automatic wait_results();
    while (accepted_count != queued_count || expected_blur_q.size() != 0) @(posedge clk);
  endtask

  // items that release no result may still be in the pipe
  task automatic wait_idle();
    wait_results();
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_val,
                           input logic [CFG_DATA_W-1:0] h_val);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
  endtask

  // pixels of one frame, then the drain items, with stray drains and pixels when noisy; may stop early or pause halfway
  task automatic queue_frame(input int unsigned stop_at, input bit noisy, input bit pause_mid);
    int unsigned total;
    total = fw * fh;
    for (int unsigned i = 0; i < total + fw + 1; i++) begin
      if (i == stop_at) return;
      if (pause_mid && i == total / 2) wait_results();
      if (i < total) begin
        if (noisy && $urandom_range(0, 19) == 0)
          push_item(OP_DRAIN, rand_chan(), rand_chan(), rand_chan());
        push_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      end else begin
        push_item((noisy && $urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN,
                  rand_chan(), rand_chan(), rand_chan());
      end
      random_count++;
    end
  endtask

  initial begin
    int unsigned w_val, h_val, hi_bits, nframes, cut_at;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: a few pixels, too few for any result, then restart
    for (int i = 0; i < 3; i++) push_item(OP_PIXEL, 8'hFF, 8'h00, 8'h80);

    // below-range writes clamp to a 2x2 frame: all corners
    set_frame(13'd1, 13'd0);
    push_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    push_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(OP_PIXEL, 8'hFF, 8'h00, 8'hAA);
    push_item(OP_PIXEL, 8'h01, 8'hFE, 8'h55);
    push_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    push_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);

    // 3x3: corners, edges and a full interior window
    set_frame(13'd3, 13'd3);
    for (int i = 0; i < 9; i++)
      push_item(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'(i * 32), 8'(8'hFF - i * 3));
    push_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

    // above-range writes clamp to the widest and tallest frames; only their
    // opening rows are sent, the next register write restarts them
    set_frame(13'd2047, 13'd2);
    queue_frame(fw + 40, 1'b0, 1'b1);
    set_frame(13'd2, 13'h1FFF);
    queue_frame(TALL_CUT, 1'b1, 1'b0);

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 12);
      h_val = $urandom_range(2, 8);
      if ($urandom_range(0, 9) == 0) w_val = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) h_val = $urandom_range(0, 1);
      hi_bits = $urandom_range(0, 3);
      set_frame(13'(w_val | (hi_bits << FW_BITS)), 13'(h_val));
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        if ($urandom_range(0, 9) == 0) begin
          // abandoned frame; the next register write restarts it
          cut_at = $urandom_range(0, fw * fh + fw);
          queue_frame(cut_at, 1'b1, 1'b0);
          break;
        end
        queue_frame(WHOLE_FRAME, 1'b1, $urandom_range(0, 5) == 0);
      end
    end

    wait_idle();
    if (mismatch_count == 0 && expected_blur_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
